[rtl/core/ii_tex_pkg.sv]
// ----------------------------------------------------------------------------
// ii_tex_pkg
// Shared constants, types and helpers for the integral image / texture block.
// ----------------------------------------------------------------------------
package ii_tex_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Counter and dimension widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int DEN_W = WID_W + HGT_W;

  // Field and accumulator widths
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int PIX_W      = 8;
  localparam int TEX_W      = PIX_W + 1;
  localparam int ROWACC_W   = 18;
  localparam int ROWTEX_W   = 19;
  localparam int SUM_W      = 28;
  localparam int SUMTEX_W   = 29;
  localparam int TOT_W      = 30;
  localparam int MEAN_W     = 9;

  // Reset geometry
  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(320);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(240);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // One line buffer entry
  typedef struct packed {
    logic [SUM_W-1:0]    sum_red;
    logic [SUMTEX_W-1:0] sum_texture;
    logic [SUM_W-1:0]    sum_green;
    logic [SUM_W-1:0]    sum_blue;
    logic [PIX_W-1:0]    red;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // Divider status back to the top level
  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quot;
  } div_status_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v == '0) begin
      r = HGT_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = HGT_W'(MAX_HEIGHT);
    end else begin
      r = HGT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

[rtl/core/ii_tex_ram.sv]
// ----------------------------------------------------------------------------
// ii_tex_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ii_tex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ii_tex_div.sv]
// ----------------------------------------------------------------------------
// ii_tex_div
// Restoring divider for the frame mean texture, one quotient bit a cycle,
// saturating to all ones.
// ----------------------------------------------------------------------------
module ii_tex_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ii_tex_pkg::TOT_W-1:0]    dividend_i,
  input  logic [ii_tex_pkg::DEN_W-1:0]    divisor_i,
  output ii_tex_pkg::div_status_t         status_o
);

  import ii_tex_pkg::*;

  localparam int CMP_W  = DEN_W + MEAN_W + 1;
  localparam int STEP_W = $clog2(MEAN_W);

  typedef enum logic [2:0] {
    DIV_IDLE  = 3'b001,
    DIV_CHECK = 3'b010,
    DIV_STEP  = 3'b100
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [TOT_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [CMP_W-1:0]  sh_q, sh_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [MEAN_W-1:0] quot_q, quot_d;
  logic              done_q, done_d;

  logic [CMP_W-1:0]  rem_ext;
  logic [CMP_W-1:0]  sat_lim;
  logic              ge;

  assign rem_ext = CMP_W'(rem_q);
  assign sat_lim = CMP_W'(den_q) << MEAN_W;
  assign ge      = (rem_ext >= sh_q);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    den_d   = den_q;
    sh_d    = sh_q;
    step_d  = step_q;
    quot_d  = quot_q;
    done_d  = 1'b0;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          rem_d   = dividend_i;
          den_d   = divisor_i;
          state_d = DIV_CHECK;
        end
      end
      DIV_CHECK: begin
        if (rem_ext >= sat_lim) begin
          // quotient does not fit: saturate
          quot_d  = '1;
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          quot_d  = '0;
          sh_d    = CMP_W'(den_q) << (MEAN_W - 1);
          step_d  = STEP_W'(MEAN_W - 1);
          state_d = DIV_STEP;
        end
      end
      DIV_STEP: begin
        if (ge) begin
          rem_d = rem_q - sh_q[TOT_W-1:0];
        end
        quot_d = {quot_q[MEAN_W-2:0], ge};
        sh_d   = sh_q >> 1;
        if (step_q == '0) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    sh_q   <= sh_d;
    step_q <= step_d;
    quot_q <= quot_d;
  end

  assign status_o.done = done_q;
  assign status_o.quot = quot_q;

endmodule

[rtl/core/integral_image_texture_top.sv]
// ----------------------------------------------------------------------------
// integral_image_texture_top
// Streaming summed-area tables of red, green, blue and a red texture measure.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in channel (in_valid_i / in_ready_o) in raster order.
//   Each accepted beat gives one beat on the out channel (out_valid_o /
//   out_ready_i) with the four area sums, frame_last_o and, on the final pixel
//   of a frame, the truncated mean texture (zero on every other beat).
//   Frame geometry is set through the cfg write channel (cfg_valid_i,
//   cfg_index_i, cfg_data_i; cfg_ready_o is always high); the user must write
//   it only while no pixel is in flight, the block does not enforce this.
// Timing:
//   An input beat is registered in the compute stage, then in the output
//   register. One pixel per clock is sustained while the output is free:
//   one line buffer read and one write per pixel, with forwarding when a
//   column is read just as it is written (width one). The final pixel of
//   a frame runs through a bit-serial divider, during which the input stalls.
// Reset:
//   Counters, row accumulators and the texture total clear; geometry returns
//   to 320 x 240. The line buffer is not cleared: row zero never uses it.
// Back-pressure:
//   A stalled receiver holds the output register; one more pixel waits in the
//   compute stage, then in_ready_o drops.
// ----------------------------------------------------------------------------
module integral_image_texture_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ii_tex_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ii_tex_pkg::CFG_W-1:0]        cfg_data_i,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ii_tex_pkg::PIX_W-1:0]        red_i,
  input  logic [ii_tex_pkg::PIX_W-1:0]        green_i,
  input  logic [ii_tex_pkg::PIX_W-1:0]        blue_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ii_tex_pkg::SUM_W-1:0]        sum_red_o,
  output logic [ii_tex_pkg::SUMTEX_W-1:0]     sum_texture_o,
  output logic [ii_tex_pkg::SUM_W-1:0]        sum_green_o,
  output logic [ii_tex_pkg::SUM_W-1:0]        sum_blue_o,
  output logic [ii_tex_pkg::MEAN_W-1:0]       texture_mean_o,
  output logic                                frame_last_o
);

  import ii_tex_pkg::*;

  localparam int CXW = COL_W + 1;
  localparam int RXW = ROW_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [DEN_W-1:0] area_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_WIDTH;
      frame_height_q <= RST_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign w_eff = clamp_width(frame_width_q);
  assign h_eff = clamp_height(frame_height_q);

  // pixel count per frame, settled long before any frame end
  always_ff @(posedge clk_i) begin
    area_q <= DEN_W'(w_eff) * DEN_W'(h_eff);
  end

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic in_acc;
  logic s1_valid_q;
  logic s1_adv;
  logic out_free;
  logic out_valid_q;
  logic mean_wait_q;
  div_status_t div_st;

  assign out_free   = !mean_wait_q && (!out_valid_q || out_ready_i);
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Raster counters (advance on input beat)
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             row_end, frame_end;

  assign row_end   = (CXW'(col_q) + CXW'(1)) >= CXW'(w_eff);
  assign frame_end = row_end && ((RXW'(row_q) + RXW'(1)) >= RXW'(h_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (row_end) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage registers
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic [COL_W-1:0] s1_addr_q;
  logic             s1_xfirst_q, s1_yfirst_q, s1_last_q;
  logic             fwd_q;
  line_t            fwd_data_q;

  // --------------------------------------------------------------------------
  // Line buffer
  // --------------------------------------------------------------------------
  line_t ram_rdata, ram_wdata;

  ii_tex_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_red_q    <= red_i;
      s1_green_q  <= green_i;
      s1_blue_q   <= blue_i;
      s1_addr_q   <= col_q;
      s1_xfirst_q <= (col_q == '0);
      s1_yfirst_q <= (row_q == '0);
      s1_last_q   <= frame_end;
      // column written this very cycle: RAM still returns the old word
      fwd_q       <= s1_adv && (s1_addr_q == col_q);
      fwd_data_q  <= ram_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Read-modify-write datapath
  // --------------------------------------------------------------------------
  logic [ROWACC_W-1:0] racc_q, gacc_q, bacc_q;
  logic [ROWTEX_W-1:0] tacc_q;
  logic [PIX_W-1:0]    left_red_q;
  logic [TOT_W-1:0]    tex_total_q;

  line_t               above;
  logic [PIX_W-1:0]    up_px, left_px;
  logic [TEX_W-1:0]    tex;
  logic [ROWACC_W-1:0] racc_d, gacc_d, bacc_d;
  logic [ROWTEX_W-1:0] tacc_d;
  logic [TOT_W-1:0]    tex_total_d;

  always_comb begin
    above   = fwd_q ? fwd_data_q : ram_rdata;
    up_px   = s1_yfirst_q ? '0 : above.red;
    left_px = s1_xfirst_q ? '0 : left_red_q;
    tex     = TEX_W'(abs_diff(s1_red_q, left_px)) + TEX_W'(abs_diff(s1_red_q, up_px));

    racc_d = (s1_xfirst_q ? '0 : racc_q) + ROWACC_W'(s1_red_q);
    gacc_d = (s1_xfirst_q ? '0 : gacc_q) + ROWACC_W'(s1_green_q);
    bacc_d = (s1_xfirst_q ? '0 : bacc_q) + ROWACC_W'(s1_blue_q);
    tacc_d = (s1_xfirst_q ? '0 : tacc_q) + ROWTEX_W'(tex);
    tex_total_d = tex_total_q + TOT_W'(tex);

    ram_wdata.red = s1_red_q;
    if (s1_yfirst_q) begin
      ram_wdata.sum_red     = SUM_W'(racc_d);
      ram_wdata.sum_texture = SUMTEX_W'(tacc_d);
      ram_wdata.sum_green   = SUM_W'(gacc_d);
      ram_wdata.sum_blue    = SUM_W'(bacc_d);
    end else begin
      ram_wdata.sum_red     = SUM_W'(racc_d) + above.sum_red;
      ram_wdata.sum_texture = SUMTEX_W'(tacc_d) + above.sum_texture;
      ram_wdata.sum_green   = SUM_W'(gacc_d) + above.sum_green;
      ram_wdata.sum_blue    = SUM_W'(bacc_d) + above.sum_blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      racc_q      <= '0;
      gacc_q      <= '0;
      bacc_q      <= '0;
      tacc_q      <= '0;
      left_red_q  <= '0;
      tex_total_q <= '0;
    end else if (s1_adv) begin
      racc_q      <= racc_d;
      gacc_q      <= gacc_d;
      bacc_q      <= bacc_d;
      tacc_q      <= tacc_d;
      left_red_q  <= s1_red_q;
      tex_total_q <= s1_last_q ? '0 : tex_total_d;
    end
  end

  // --------------------------------------------------------------------------
  // Frame mean divider
  // --------------------------------------------------------------------------
  ii_tex_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s1_adv && s1_last_q),
    .dividend_i (tex_total_d),
    .divisor_i  (area_q),
    .status_o   (div_st)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]    out_red_q, out_green_q, out_blue_q;
  logic [SUMTEX_W-1:0] out_tex_q;
  logic [MEAN_W-1:0]   out_mean_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mean_wait_q <= 1'b0;
    end else begin
      if (s1_adv && s1_last_q) begin
        mean_wait_q <= 1'b1;
        out_valid_q <= 1'b0;
      end else if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (div_st.done) begin
        mean_wait_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_red_q   <= ram_wdata.sum_red;
      out_tex_q   <= ram_wdata.sum_texture;
      out_green_q <= ram_wdata.sum_green;
      out_blue_q  <= ram_wdata.sum_blue;
      out_last_q  <= s1_last_q;
      out_mean_q  <= '0;
    end else if (div_st.done) begin
      out_mean_q  <= div_st.quot;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sum_red_o      = out_red_q;
  assign sum_texture_o  = out_tex_q;
  assign sum_green_o    = out_green_q;
  assign sum_blue_o     = out_blue_q;
  assign texture_mean_o = out_mean_q;
  assign frame_last_o   = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // no beat is shown while the frame mean is still being worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_wait_q |-> !out_valid_q)
    else $error("output valid while mean pending");

  // divider only finishes for a frame end that is waiting on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> mean_wait_q)
    else $error("divider done without a pending frame end");

  // mean reads zero away from frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_mean_q == '0))
    else $error("non-zero mean on ordinary pixel");

  // compute stage never overwritten while it holds an unfinished pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("compute stage lost a pixel");

endmodule

[tb/tb_integral_image_texture_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integral_image_texture_top
// Self-checking bench for the streaming summed-area / texture block. A queue
// of pixels feeds a clocked driver with random gaps; a clocked monitor with
// random back-pressure compares every output beat against sums predicted at
// the moment each input beat is accepted. Geometry is rewritten between
// phases, at frame boundaries and mid-frame, including out-of-range values.
// ----------------------------------------------------------------------------
module tb_integral_image_texture_top;
  import ii_tex_pkg::*;

  // Stimulus sizing and a few timing knobs
  localparam int unsigned RANDOM_PIXELS = 650;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned PRINT_CAP     = 40;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum_red;
    logic [SUMTEX_W-1:0] sum_texture;
    logic [SUM_W-1:0]    sum_green;
    logic [SUM_W-1:0]    sum_blue;
    logic [MEAN_W-1:0]   texture_mean;
    logic                frame_last;
  } area_sums_t;

  // DUT connections; everything driven has a known value from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [PIX_W-1:0]    red_i       = '0;
  logic [PIX_W-1:0]    green_i     = '0;
  logic [PIX_W-1:0]    blue_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SUM_W-1:0]    sum_red_o;
  logic [SUMTEX_W-1:0] sum_texture_o;
  logic [SUM_W-1:0]    sum_green_o;
  logic [SUM_W-1:0]    sum_blue_o;
  logic [MEAN_W-1:0]   texture_mean_o;
  logic                frame_last_o;

  integral_image_texture_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sum_red_o      (sum_red_o),
    .sum_texture_o  (sum_texture_o),
    .sum_green_o    (sum_green_o),
    .sum_blue_o     (sum_blue_o),
    .texture_mean_o (texture_mean_o),
    .frame_last_o   (frame_last_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pixel_t      pixel_backlog[$];   // pixels waiting for the driver
  area_sums_t  pending_sums[$];    // predicted beats not yet seen on the output
  int unsigned px_queued   = 0;    // pixels handed to the driver so far
  int unsigned px_accepted = 0;    // pixels the block has taken
  int unsigned mismatches  = 0;
  bit          quiet_send  = 1'b0; // no gaps on the input side
  bit          quiet_recv  = 1'b0; // no stalls on the output side
  int unsigned holds_asked = 0;    // long receiver hold-offs requested
  int unsigned holds_done  = 0;

  // Predictor copy of the geometry registers (reset values 320 x 240)
  logic [CFG_W-1:0] geo_width  = CFG_W'(320);
  logic [CFG_W-1:0] geo_height = CFG_W'(240);

  // Predictor copy of the block's state
  logic [SUM_W-1:0]    line_sum_red  [MAX_WIDTH];
  logic [SUMTEX_W-1:0] line_sum_tex  [MAX_WIDTH];
  logic [SUM_W-1:0]    line_sum_green[MAX_WIDTH];
  logic [SUM_W-1:0]    line_sum_blue [MAX_WIDTH];
  logic [PIX_W-1:0]    line_red      [MAX_WIDTH];
  logic [ROWACC_W-1:0] acc_red   = '0;
  logic [ROWTEX_W-1:0] acc_tex   = '0;
  logic [ROWACC_W-1:0] acc_green = '0;
  logic [ROWACC_W-1:0] acc_blue  = '0;
  logic [PIX_W-1:0]    prev_red  = '0;
  logic [TOT_W-1:0]    tex_total = '0;
  int unsigned         col_pos   = 0;
  int unsigned         row_pos   = 0;
  // Line buffer columns are written from zero upwards, so the written set
  // is always a prefix; this is its length.
  int unsigned         cols_written = 0;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Zero acts as one, anything past the limit acts as the limit
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v,
                                          input int unsigned limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Extremes turn up often so the texture reaches its limits
  function automatic logic [PIX_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic int unsigned frame_remaining();
    int unsigned w, h, n;
    w = eff_dim(geo_width, MAX_WIDTH);
    h = eff_dim(geo_height, MAX_HEIGHT);
    n = (col_pos + 1 >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) n += (h - 1 - row_pos) * w;
    return n;
  endfunction

  // A width change mid-frame must not make a later row read a line buffer
  // column that was never written. During row zero the rest of the row
  // writes whatever the next row will read.
  function automatic bit width_change_safe(input logic [CFG_W-1:0] v);
    int unsigned nw, top;
    if (row_pos == 0) return 1'b1;
    nw  = eff_dim(v, MAX_WIDTH);
    top = (col_pos > nw - 1) ? col_pos : nw - 1;
    return top < cols_written;
  endfunction

  // Predict the beat for one accepted pixel and advance the state copy
  function automatic void predict_area_sums(input pixel_t p);
    int unsigned w, h, xi, red_v, left_px, up_px, tex, q;
    bit          row_end, last;
    area_sums_t  e;
    w       = eff_dim(geo_width, MAX_WIDTH);
    h       = eff_dim(geo_height, MAX_HEIGHT);
    xi      = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    red_v   = 32'(p.red);
    left_px = (col_pos > 0) ? int'(prev_red) : 0;
    up_px   = (row_pos > 0) ? int'(line_red[xi]) : 0;
    tex     = ((red_v >= left_px) ? red_v - left_px : left_px - red_v) +
              ((red_v >= up_px) ? red_v - up_px : up_px - red_v);
    row_end = (col_pos + 1 >= w);
    last    = row_end && (row_pos + 1 >= h);

    if (col_pos == 0) begin
      acc_red   = '0;
      acc_tex   = '0;
      acc_green = '0;
      acc_blue  = '0;
    end
    acc_red   = acc_red + ROWACC_W'(p.red);
    acc_tex   = acc_tex + ROWTEX_W'(tex);
    acc_green = acc_green + ROWACC_W'(p.green);
    acc_blue  = acc_blue + ROWACC_W'(p.blue);
    tex_total = tex_total + TOT_W'(tex);

    e = '0;
    e.sum_red     = SUM_W'(acc_red);
    e.sum_texture = SUMTEX_W'(acc_tex);
    e.sum_green   = SUM_W'(acc_green);
    e.sum_blue    = SUM_W'(acc_blue);
    if (row_pos > 0) begin
      e.sum_red     = SUM_W'(acc_red) + line_sum_red[xi];
      e.sum_texture = SUMTEX_W'(acc_tex) + line_sum_tex[xi];
      e.sum_green   = SUM_W'(acc_green) + line_sum_green[xi];
      e.sum_blue    = SUM_W'(acc_blue) + line_sum_blue[xi];
    end
    line_sum_red[xi]   = e.sum_red;
    line_sum_tex[xi]   = e.sum_texture;
    line_sum_green[xi] = e.sum_green;
    line_sum_blue[xi]  = e.sum_blue;
    line_red[xi]       = p.red;
    if (xi + 1 > cols_written) cols_written = xi + 1;
    prev_red = p.red;

    if (last) begin
      q = int'(tex_total) / (w * h);
      e.texture_mean = (q > 511) ? MEAN_W'(511) : MEAN_W'(q);
      e.frame_last   = 1'b1;
      tex_total = '0;
      col_pos   = 0;
      row_pos   = 0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    pending_sums.push_back(e);
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_beat();
    area_sums_t want;
    if (pending_sums.size() == 0) begin
      flag_mismatch("output beat with none pending", 64'(sum_red_o), 64'(0));
    end else begin
      want = pending_sums.pop_front();
      if (sum_red_o !== want.sum_red)
        flag_mismatch("sum_red", 64'(sum_red_o), 64'(want.sum_red));
      if (sum_texture_o !== want.sum_texture)
        flag_mismatch("sum_texture", 64'(sum_texture_o), 64'(want.sum_texture));
      if (sum_green_o !== want.sum_green)
        flag_mismatch("sum_green", 64'(sum_green_o), 64'(want.sum_green));
      if (sum_blue_o !== want.sum_blue)
        flag_mismatch("sum_blue", 64'(sum_blue_o), 64'(want.sum_blue));
      if (texture_mean_o !== want.texture_mean)
        flag_mismatch("texture_mean", 64'(texture_mean_o), 64'(want.texture_mean));
      if (frame_last_o !== want.frame_last)
        flag_mismatch("frame_last", 64'(frame_last_o), 64'(want.frame_last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one beat at a time from the backlog, random gaps between.
  // Prediction happens at the edge where the beat is taken.
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;
  bit          offer_px;
  pixel_t      staged_px;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      red_i      <= '0;
      green_i    <= '0;
      blue_i     <= '0;
      send_gap   = 0;
    end else begin
      offer_px = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_area_sums('{red: red_i, green: green_i, blue: blue_i});
        px_accepted++;
        offer_px = 1'b0;
        send_gap = pick_gap(quiet_send);
      end
      if (!offer_px) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_backlog.size() > 0) begin
          staged_px = pixel_backlog.pop_front();
          red_i    <= staged_px.red;
          green_i  <= staged_px.green;
          blue_i   <= staged_px.blue;
          offer_px = 1'b1;
        end
      end
      // single assignment per edge keeps valid steady across back-to-back beats
      in_valid_i <= offer_px;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each beat, then picks the next stall. A requested
  // long hold-off overrides the random stall so the block backs up.
  // --------------------------------------------------------------------------
  int unsigned recv_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  = 0;
    end else begin
      if (out_valid_o && out_ready_i) check_beat();
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        recv_stall = LONG_HOLD;
      end else if (out_valid_o && out_ready_i) begin
        recv_stall = pick_gap(quiet_recv);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  task automatic write_geometry(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    // beat taken at this edge
    if (idx == CFG_FRAME_WIDTH) geo_width = val;
    else geo_height = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_pixel(input int unsigned r, input int unsigned g,
                             input int unsigned b);
    pixel_backlog.push_back('{red: PIX_W'(r), green: PIX_W'(g), blue: PIX_W'(b)});
    px_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) begin
      pixel_backlog.push_back('{red: pick_level(), green: pick_level(),
                                blue: pick_level()});
      px_queued++;
    end
  endtask

  // Sender holds back until every pixel is in and every beat has come out.
  task automatic drain();
    while (px_accepted != px_queued || pending_sums.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 85) return CFG_W'($urandom_range(12, 1));
    return CFG_W'($urandom_range(40, 13));
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 90) return CFG_W'($urandom_range(6, 1));
    return CFG_W'($urandom_range(12, 7));
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned      random_px;
    int unsigned      n;
    logic [CFG_W-1:0] nw;
    random_px = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // A few pixels at the reset geometry, extremes of every channel
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(0, 255, 0);
    queue_pixel(255, 0, 255);
    queue_pixel(170, 85, 170);
    drain();

    // Width shrinks mid-row: column five is already past the new width, so
    // the row ends on the next beat; height 2 ends the frame after row one.
    write_geometry(CFG_FRAME_WIDTH, CFG_W'(4));
    write_geometry(CFG_FRAME_HEIGHT, CFG_W'(2));
    queue_pixel(255, 1, 254);
    queue_pixel(0, 128, 127);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 127, 128);
    drain();

    // Zero width and height act as one: single-pixel frames, the first at
    // the largest possible mean
    write_geometry(CFG_FRAME_WIDTH, '0);
    write_geometry(CFG_FRAME_HEIGHT, '0);
    queue_pixel(255, 255, 255);
    queue_pixel(0, 0, 0);
    drain();

    // One-wide column: each pixel reads the column it wrote the beat before
    write_geometry(CFG_FRAME_HEIGHT, CFG_W'(4));
    queue_pixel(255, 3, 200);
    queue_pixel(0, 250, 7);
    queue_pixel(255, 9, 99);
    queue_pixel(0, 255, 1);
    drain();

    // Height drops below the current row mid-frame: frame ends at row end
    write_geometry(CFG_FRAME_WIDTH, CFG_W'(3));
    write_geometry(CFG_FRAME_HEIGHT, CFG_W'(3));
    queue_random(4);
    drain();
    write_geometry(CFG_FRAME_HEIGHT, CFG_W'(1));
    queue_random(2);
    drain();

    // Random phases: mostly whole frames, sometimes a frame cut short so the
    // next geometry write lands mid-frame
    while (random_px < RANDOM_PIXELS) begin
      quiet_send = ($urandom_range(4) == 0);
      quiet_recv = ($urandom_range(4) == 0);
      if ($urandom_range(2) != 0) begin
        nw = pick_width();
        if (width_change_safe(nw)) write_geometry(CFG_FRAME_WIDTH, nw);
      end
      if ($urandom_range(2) != 0) write_geometry(CFG_FRAME_HEIGHT, pick_height());
      n = frame_remaining();
      if ($urandom_range(3) == 0) n = $urandom_range(n, 1);
      queue_random(n);
      random_px += n;
      drain();
    end

    // Finish any open frame so the wide one starts at the origin
    if (col_pos != 0 || row_pos != 0) begin
      queue_random(frame_remaining());
      drain();
    end

    // Widest row: all-ones width clamps to the maximum, single row. Sender
    // runs flat out while the receiver holds off, so the input stalls.
    write_geometry(CFG_FRAME_WIDTH, '1);
    write_geometry(CFG_FRAME_HEIGHT, '0);
    quiet_send = 1'b1;
    quiet_recv = 1'b0;
    holds_asked++;
    queue_random(MAX_WIDTH);
    drain();

    // Tallest setting on a one-wide column, then cut down mid-frame; the
    // texture over the extra rows pushes the mean into saturation
    quiet_send = 1'b0;
    write_geometry(CFG_FRAME_WIDTH, '0);
    write_geometry(CFG_FRAME_HEIGHT, '1);
    queue_random(31);
    drain();
    write_geometry(CFG_FRAME_HEIGHT, CFG_W'(5));
    queue_random(1);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[integral_image_texture_top.f]
rtl/core/ii_tex_pkg.sv
rtl/core/ii_tex_ram.sv
rtl/core/ii_tex_div.sv
rtl/core/integral_image_texture_top.sv
tb/tb_integral_image_texture_top.sv
